// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset
`define ILI_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("property check failed");

// Check that a condition never holds outside reset
`define ILI_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ILI_ASSERT(lbl, clk, rstn, prop)
`define ILI_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ===== rtl/ili_pkg.sv =====
package ili_pkg;

    // Default sizes
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int ACTION_W = 2;
    localparam int POS_W    = 7;
    localparam int ITEM_W   = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // Cells per first-level group of the read select
    localparam int GROUP = 8;

    // Request actions
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Shift command broadcast to every cell
    typedef struct packed {
        logic ins;   // open a slot at the position and write the new value
        logic rem;   // close the slot at the position
    } cell_op_t;

endpackage

// ===== rtl/ili_cell.sv =====
module ili_cell #(
    parameter int DATA_WIDTH = ili_pkg::DATA_WIDTH_DEF,
    parameter int IDX_W      = 8,
    parameter int INDEX      = 0
) (
    input  logic                  aclk,
    input  ili_pkg::cell_op_t     op,
    input  logic [IDX_W-1:0]      pos,
    input  logic [DATA_WIDTH-1:0] item,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  hit
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic                  at_pos;
    logic                  above_pos;

    // Locate this cell against the request position
    assign at_pos    = (32'(pos) == 32'(INDEX));
    assign above_pos = (32'(pos) <  32'(INDEX));

    // Take the new value, shift up from the left or close up from the right
    always_ff @(posedge aclk) begin
        if (op.ins) begin
            if (at_pos) begin
                data_reg <= item;
            end else if (above_pos) begin
                data_reg <= left_data;
            end
        end else if (op.rem && (at_pos || above_pos)) begin
            data_reg <= right_data;
        end
    end

    assign data = data_reg;
    assign hit  = at_pos;

endmodule

// ===== rtl/ili_gather.sv =====
module ili_gather #(
    parameter int CAPACITY   = ili_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ili_pkg::DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  load,
    input  logic                  hit [CAPACITY],
    input  logic [DATA_WIDTH-1:0] cell_data [CAPACITY],
    output logic [DATA_WIDTH-1:0] sel_data
);

    localparam int NGRP = (CAPACITY + ili_pkg::GROUP - 1) / ili_pkg::GROUP;

    logic [DATA_WIDTH-1:0] grp_next [NGRP];
    logic [DATA_WIDTH-1:0] grp_reg  [NGRP];

    // Merge the selected cell of each group
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_next[g] = '0;
            for (int k = 0; k < ili_pkg::GROUP; k++) begin
                if ((g * ili_pkg::GROUP + k) < CAPACITY) begin
                    if (hit[g * ili_pkg::GROUP + k]) begin
                        grp_next[g] = grp_next[g] | cell_data[g * ili_pkg::GROUP + k];
                    end
                end
            end
        end
    end

    // Hold the group results before the list moves
    always_ff @(posedge aclk) begin
        if (load) begin
            grp_reg <= grp_next;
        end
    end

    // Merge the groups; at most one of them is non-zero
    always_comb begin
        sel_data = '0;
        for (int g = 0; g < NGRP; g++) begin
            sel_data = sel_data | grp_reg[g];
        end
    end

endmodule

// ===== rtl/indexed_insertion_list.sv =====
// An accepted request passes through the execute and deliver steps of the control
//   sequencer before its result appears on m_axis; no new request is taken until the last
//   is delivered. The cells at or above the position shift at once in the execute step, whatever the position.
// A result waiting on m_axis holds the sequencer in its deliver step.
// Reset: entry count, empty value and handshake state clear; entries are not
//   cleared and need no clearing pass, since only written positions are read.
module indexed_insertion_list #(
    parameter int CAPACITY   = ili_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ili_pkg::DATA_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration: empty value
    input  logic                          cfg_wr_en,
    input  logic [ili_pkg::VALUE_W-1:0]   cfg_wr_data,
    // Requests
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [1:0] action, [8:2] position, [40:9] item_value, [47:41] zero
    input  logic [ili_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // Results
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] value, [33:32] status, [40:34] count, [47:41] zero
    output logic [ili_pkg::M_TDATA_W-1:0] m_axis_tdata
);

`include "assert_macros.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > ili_pkg::POS_W) ? CNT_W : ili_pkg::POS_W;

    localparam logic [ili_pkg::COUNT_W-1:0] FULL_COUNT = ili_pkg::COUNT_W'(CAPACITY);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                     state_reg;
    logic [1:0]                     state_next;
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;
    logic [ili_pkg::VALUE_W-1:0]    empty_reg;

    logic [ili_pkg::ACTION_W-1:0]   act_reg;
    logic [ili_pkg::POS_W-1:0]      pos_reg;
    logic [ili_pkg::ITEM_W-1:0]     item_reg;

    logic [ili_pkg::STATUS_W-1:0]   status_reg;
    logic [ili_pkg::STATUS_W-1:0]   status_next;
    logic                           rd_reg;
    logic                           rd_next;

    logic                           m_valid_reg;
    logic [ili_pkg::VALUE_W-1:0]    m_value_reg;
    logic [ili_pkg::STATUS_W-1:0]   m_status_reg;
    logic [ili_pkg::COUNT_W-1:0]    m_count_reg;

    logic                           accept;
    logic                           exec;
    logic                           deliver;
    logic                           is_add;
    logic                           range_err;
    logic                           full;
    logic                           res_full;
    logic [CMP_W-1:0]               pos_eff;
    logic [CMP_W-1:0]               count_ext;
    logic [63:0]                    item_sx;
    logic [DATA_WIDTH-1:0]          item_st;
    logic [63:0]                    rd_ext;
    logic [DATA_WIDTH-1:0]          sel_data;
    ili_pkg::cell_op_t              cell_op;
    logic [DATA_WIDTH-1:0]          cell_data [CAPACITY];
    logic                           cell_hit  [CAPACITY];

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign exec    = (state_reg == S_EXEC);
    assign deliver = (state_reg == S_DONE) && (!m_valid_reg || m_axis_tready);

    assign s_axis_tready = (state_reg == S_IDLE);

    // Sequence one request: accept, execute, deliver
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (deliver) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Capture the request
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg  <= s_axis_tdata[1:0];
            pos_reg  <= s_axis_tdata[8:2];
            item_reg <= s_axis_tdata[40:9];
        end
    end

    // Decode the request against the current count
    always_comb begin
        count_ext = CMP_W'(count_reg);
        pos_eff   = (act_reg == ili_pkg::ACT_APPEND) ? count_ext : CMP_W'(pos_reg);
        is_add    = (act_reg == ili_pkg::ACT_APPEND) || (act_reg == ili_pkg::ACT_INSERT);
        full      = (count_reg >= CNT_W'(CAPACITY));
        range_err = is_add ? (pos_eff > count_ext) : (pos_eff >= count_ext);

        if (range_err) begin
            status_next = ili_pkg::ST_RANGE;
        end else if (is_add && full) begin
            status_next = ili_pkg::ST_FULL;
        end else begin
            status_next = ili_pkg::ST_OK;
        end

        rd_next     = !is_add && !range_err;
        cell_op.ins = exec && is_add && (status_next == ili_pkg::ST_OK);
        cell_op.rem = exec && (act_reg == ili_pkg::ACT_REMOVE) && !range_err;

        count_next = count_reg;
        if (cell_op.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cell_op.rem) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Keep DATA_WIDTH bits of the sign-extended item
    assign item_sx = {{32{item_reg[31]}}, item_reg};
    assign item_st = item_sx[DATA_WIDTH-1:0];

    // Row of storage cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic [DATA_WIDTH-1:0] right_data;

        if (i == 0) begin : g_first
            assign left_data = cell_data[i];
        end else begin : g_left
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_data = cell_data[i];
        end else begin : g_right
            assign right_data = cell_data[i+1];
        end

        ili_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (CMP_W),
            .INDEX      (i)
        ) u_cell (
            .aclk       (aclk),
            .op         (cell_op),
            .pos        (pos_eff),
            .item       (item_st),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i]),
            .hit        (cell_hit[i])
        );
    end

    // Pick the entry at the position before the row moves
    ili_gather #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_gather (
        .aclk      (aclk),
        .load      (exec),
        .hit       (cell_hit),
        .cell_data (cell_data),
        .sel_data  (sel_data)
    );

    assign rd_ext = 64'(sel_data);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            empty_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_wr_en) begin
                empty_reg <= cfg_wr_data;
            end
            if (deliver) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the outcome of the execute step
    always_ff @(posedge aclk) begin
        if (exec) begin
            status_reg <= status_next;
            rd_reg     <= rd_next;
        end
    end

    // Load the result register
    always_ff @(posedge aclk) begin
        if (deliver) begin
            m_value_reg  <= rd_reg ? rd_ext[ili_pkg::VALUE_W-1:0] : empty_reg;
            m_status_reg <= status_reg;
            m_count_reg  <= ili_pkg::COUNT_W'(count_reg);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, m_count_reg, m_status_reg, m_value_reg};

    // Flag a full-list rejection waiting on the result side
    assign res_full = m_valid_reg && (m_status_reg == ili_pkg::ST_FULL);

    `ILI_NEVER(a_count_bound, aclk, aresetn, count_reg > CNT_W'(CAPACITY))
    `ILI_ASSERT(a_accept_exec, aclk, aresetn, accept |=> (state_reg == S_EXEC))
    `ILI_ASSERT(a_count_hold, aclk, aresetn, (state_reg != S_EXEC) |=> $stable(count_reg))
    `ILI_ASSERT(a_full_count, aclk, aresetn, res_full |-> (m_count_reg == FULL_COUNT))

endmodule
